// ===== hw/rtl/tfn_pkg.sv =====
// Shared widths and types for the triangle face normal unit.
`timescale 1ns / 1ps
package tfn_pkg;

   localparam int COORD_BITS       = 24;
   localparam int NORMAL_FRAC_BITS = 14;

   localparam int EDGE_BITS  = COORD_BITS + 1;          // B-A, C-A
   localparam int PROD_BITS  = 2 * EDGE_BITS;           // edge product, signed
   localparam int CROSS_BITS = PROD_BITS + 1;           // cross component, signed
   localparam int MAG_BITS   = PROD_BITS;               // |cross component|
   localparam int HI_BITS    = (MAG_BITS + 1) / 2;
   localparam int LO_BITS    = MAG_BITS - HI_BITS;
   localparam int SQ_BITS    = 2 * MAG_BITS;            // component squared
   localparam int SUM_BITS   = SQ_BITS + 2;             // |c|^2
   localparam int M_BITS     = NORMAL_FRAC_BITS + 1;    // magnitude of a result, up to 2^F
   localparam int OUT_BITS   = NORMAL_FRAC_BITS + 2;    // signed result
   localparam int WIDE_BITS  = SUM_BITS + M_BITS + NORMAL_FRAC_BITS + 2;

   localparam int FRONT_STAGES = 6;
   localparam int LATENCY      = FRONT_STAGES + M_BITS + 1;

   typedef logic [WIDE_BITS-1:0] wide_type;

endpackage

// ===== hw/rtl/triangle_face_normal_unit.sv =====
// Top level of the triangle face normal unit.
// Usage:
//   Drive the nine vertex coordinates (signed Q12.12) on req_* and pulse
//   start. A transaction is taken at each rising edge with start high and
//   busy low; busy is always low, so one triangle can enter every cycle.
//   The result (unit normal, signed Q2.14, truncated toward zero, plus the
//   degenerate flag) appears on rsp_* with rsp_valid high for exactly one
//   cycle. Throughput is one triangle per cycle. The pipeline has six
//   front stages (edges, edge products, cross product, split squares,
//   squares, sum of squares), then one stage per result bit (15) of the
//   shift-and-subtract magnitude search, then the output register.
//   A zero cross product gives zero components and rsp_degenerate high.
//   Reset clears all valid bits; transactions in flight are dropped.
//   The receiver cannot stall: results must be taken when rsp_valid is high.
`timescale 1ns / 1ps
module triangle_face_normal_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [tfn_pkg::COORD_BITS-1:0]  req_a_x,
   input  logic signed [tfn_pkg::COORD_BITS-1:0]  req_a_y,
   input  logic signed [tfn_pkg::COORD_BITS-1:0]  req_a_z,
   input  logic signed [tfn_pkg::COORD_BITS-1:0]  req_b_x,
   input  logic signed [tfn_pkg::COORD_BITS-1:0]  req_b_y,
   input  logic signed [tfn_pkg::COORD_BITS-1:0]  req_b_z,
   input  logic signed [tfn_pkg::COORD_BITS-1:0]  req_c_x,
   input  logic signed [tfn_pkg::COORD_BITS-1:0]  req_c_y,
   input  logic signed [tfn_pkg::COORD_BITS-1:0]  req_c_z,
   output logic                                   rsp_valid,
   output logic signed [tfn_pkg::OUT_BITS-1:0]    rsp_normal_x,
   output logic signed [tfn_pkg::OUT_BITS-1:0]    rsp_normal_y,
   output logic signed [tfn_pkg::OUT_BITS-1:0]    rsp_normal_z,
   output logic                                   rsp_degenerate
);

   localparam int EB  = tfn_pkg::EDGE_BITS;
   localparam int PB  = tfn_pkg::PROD_BITS;
   localparam int CRB = tfn_pkg::CROSS_BITS;
   localparam int MB  = tfn_pkg::MAG_BITS;
   localparam int HB  = tfn_pkg::HI_BITS;
   localparam int LB  = tfn_pkg::LO_BITS;
   localparam int SQB = tfn_pkg::SQ_BITS;
   localparam int SB  = tfn_pkg::SUM_BITS;
   localparam int NB  = tfn_pkg::M_BITS;
   localparam int OB  = tfn_pkg::OUT_BITS;
   localparam int LAT = tfn_pkg::LATENCY;

   assign busy = 1'b0;

   // valid chain
   logic [LAT-1:0] vld_in, vld_ff;
   assign vld_in = {vld_ff[LAT-2:0], start};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: edges
   logic signed [EB-1:0] e1_in [3], e2_in [3], e1_ff [3], e2_ff [3];
   always_comb begin
      e1_in[0] = EB'(req_b_x) - EB'(req_a_x);
      e1_in[1] = EB'(req_b_y) - EB'(req_a_y);
      e1_in[2] = EB'(req_b_z) - EB'(req_a_z);
      e2_in[0] = EB'(req_c_x) - EB'(req_a_x);
      e2_in[1] = EB'(req_c_y) - EB'(req_a_y);
      e2_in[2] = EB'(req_c_z) - EB'(req_a_z);
   end

   // stage 2: edge products
   logic signed [PB-1:0] pa_in [3], pb_in [3], pa_ff [3], pb_ff [3];
   always_comb begin
      pa_in[0] = e1_ff[1] * e2_ff[2];
      pb_in[0] = e1_ff[2] * e2_ff[1];
      pa_in[1] = e1_ff[2] * e2_ff[0];
      pb_in[1] = e1_ff[0] * e2_ff[2];
      pa_in[2] = e1_ff[0] * e2_ff[1];
      pb_in[2] = e1_ff[1] * e2_ff[0];
   end

   // stage 3: cross product
   logic signed [CRB-1:0] cr_in [3], cr_ff [3];

   // stage 4: magnitude split into halves, partial squares
   logic [MB-1:0]      mag_w [3];
   logic [2*HB-1:0]    hh_in [3], hh_ff [3];
   logic [HB+LB-1:0]   hl_in [3], hl_ff [3];
   logic [2*LB-1:0]    ll_in [3], ll_ff [3];
   logic               neg4_ff [3];
   logic               deg4_in, deg4_ff;

   // stage 5: squares
   logic [SQB-1:0]     sq5_in [3], sq5_ff [3];
   logic               neg5_ff [3];
   logic               deg5_ff;

   // stage 6: sum of squares
   logic [SB-1:0]      sum6_in, sum6_ff;
   logic [SQB-1:0]     sq6_ff [3];
   logic               neg6_ff [3];
   logic               deg6_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cr_in[i] = CRB'(pa_ff[i]) - CRB'(pb_ff[i]);
         mag_w[i] = cr_ff[i][CRB-1] ? MB'(-cr_ff[i]) : MB'(cr_ff[i]);
         hh_in[i] = mag_w[i][MB-1:LB] * mag_w[i][MB-1:LB];
         hl_in[i] = mag_w[i][MB-1:LB] * mag_w[i][LB-1:0];
         ll_in[i] = mag_w[i][LB-1:0] * mag_w[i][LB-1:0];
         sq5_in[i] = (SQB'(hh_ff[i]) << (2 * LB)) + (SQB'(hl_ff[i]) << (LB + 1))
                   + SQB'(ll_ff[i]);
      end
      deg4_in = (cr_ff[0] == '0) && (cr_ff[1] == '0) && (cr_ff[2] == '0);
      sum6_in = SB'(sq5_ff[0]) + SB'(sq5_ff[1]) + SB'(sq5_ff[2]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e1_ff[i]   <= e1_in[i];
         e2_ff[i]   <= e2_in[i];
         pa_ff[i]   <= pa_in[i];
         pb_ff[i]   <= pb_in[i];
         cr_ff[i]   <= cr_in[i];
         hh_ff[i]   <= hh_in[i];
         hl_ff[i]   <= hl_in[i];
         ll_ff[i]   <= ll_in[i];
         neg4_ff[i] <= cr_ff[i][CRB-1];
         sq5_ff[i]  <= sq5_in[i];
         neg5_ff[i] <= neg4_ff[i];
         sq6_ff[i]  <= sq5_ff[i];
         neg6_ff[i] <= neg5_ff[i];
      end
      deg4_ff <= deg4_in;
      deg5_ff <= deg4_ff;
      deg6_ff <= deg5_ff;
      sum6_ff <= sum6_in;
   end

   // magnitude search, one pipe per component
   logic [NB-1:0] m_w   [3];
   logic          neg_w [3];
   for (genvar i = 0; i < 3; i++) begin : g_comp
      tfn_norm_pipe u_pipe (
         .clock   (clock),
         .sq_in   (sq6_ff[i]),
         .sum_in  (sum6_ff),
         .neg_in  (neg6_ff[i]),
         .mag_out (m_w[i]),
         .neg_out (neg_w[i])
      );
   end

   // degenerate flag rides alongside the search stages
   logic [NB-1:0] degp_in, degp_ff;
   assign degp_in = {degp_ff[NB-2:0], deg6_ff};
   always_ff @(posedge clock) begin
      degp_ff <= degp_in;
   end

   // output stage
   logic signed [OB-1:0] nrm_in [3], nrm_ff [3];
   logic                 deg_out_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (degp_ff[NB-1]) begin
            nrm_in[i] = '0;
         end else if (neg_w[i]) begin
            nrm_in[i] = -OB'(m_w[i]);
         end else begin
            nrm_in[i] = OB'(m_w[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         nrm_ff[i] <= nrm_in[i];
      end
      deg_out_ff <= degp_ff[NB-1];
   end

   assign rsp_valid      = vld_ff[LAT-1];
   assign rsp_normal_x   = nrm_ff[0];
   assign rsp_normal_y   = nrm_ff[1];
   assign rsp_normal_z   = nrm_ff[2];
   assign rsp_degenerate = deg_out_ff;

   // every result traces back to a matching transaction on start
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result without matching transaction");

   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0))
      else $error("degenerate result with nonzero normal");

   a_nondegenerate_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_degenerate) |->
         (rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0))
      else $error("nondegenerate result with zero normal");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_normal_x <= $signed(OB'(1) << tfn_pkg::NORMAL_FRAC_BITS) &&
          rsp_normal_x >= -$signed(OB'(1) << tfn_pkg::NORMAL_FRAC_BITS) &&
          rsp_normal_y <= $signed(OB'(1) << tfn_pkg::NORMAL_FRAC_BITS) &&
          rsp_normal_y >= -$signed(OB'(1) << tfn_pkg::NORMAL_FRAC_BITS) &&
          rsp_normal_z <= $signed(OB'(1) << tfn_pkg::NORMAL_FRAC_BITS) &&
          rsp_normal_z >= -$signed(OB'(1) << tfn_pkg::NORMAL_FRAC_BITS)))
      else $error("normal component out of unit range");

endmodule

// ===== hw/rtl/tfn_norm_pipe.sv =====
// Bit-per-stage pipeline that finds floor(2^F * |c_i| / sqrt(|c|^2)).
`timescale 1ns / 1ps
module tfn_norm_pipe (
   input  logic                             clock,
   input  logic [tfn_pkg::SQ_BITS-1:0]      sq_in,
   input  logic [tfn_pkg::SUM_BITS-1:0]     sum_in,
   input  logic                             neg_in,
   output logic [tfn_pkg::M_BITS-1:0]       mag_out,
   output logic                             neg_out
);

   localparam int NB = tfn_pkg::M_BITS;
   localparam int F  = tfn_pkg::NORMAL_FRAC_BITS;

   // rem = c_i^2 * 2^2F - m^2 * s, acc = m * s
   tfn_pkg::wide_type                 rem_w [NB+1];
   tfn_pkg::wide_type                 acc_w [NB+1];
   logic [NB-1:0]                     m_w   [NB+1];
   logic [tfn_pkg::SUM_BITS-1:0]      s_w   [NB+1];
   logic                              neg_w [NB+1];

   tfn_pkg::wide_type                 rem_in [NB];
   tfn_pkg::wide_type                 acc_in [NB];
   logic [NB-1:0]                     m_in   [NB];
   tfn_pkg::wide_type                 rem_ff [NB];
   tfn_pkg::wide_type                 acc_ff [NB];
   logic [NB-1:0]                     m_ff   [NB];
   logic [tfn_pkg::SUM_BITS-1:0]      s_ff   [NB];
   logic                              neg_ff [NB];

   assign rem_w[0] = tfn_pkg::wide_type'(sq_in) << (2 * F);
   assign acc_w[0] = '0;
   assign m_w[0]   = '0;
   assign s_w[0]   = sum_in;
   assign neg_w[0] = neg_in;

   for (genvar k = 0; k < NB; k++) begin : g_stage
      localparam int B = F - k;
      tfn_pkg::wide_type s_wide;
      tfn_pkg::wide_type delta;
      logic              take;

      // (m + 2^B)^2 s - m^2 s = 2^(B+1) m s + 2^(2B) s
      always_comb begin
         s_wide = tfn_pkg::wide_type'(s_w[k]);
         delta  = (acc_w[k] << (B + 1)) + (s_wide << (2 * B));
         take   = (delta <= rem_w[k]);
         rem_in[k] = rem_w[k];
         acc_in[k] = acc_w[k];
         m_in[k]   = m_w[k];
         if (take) begin
            rem_in[k]  = rem_w[k] - delta;
            acc_in[k]  = acc_w[k] + (s_wide << B);
            m_in[k][B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in[k];
         acc_ff[k] <= acc_in[k];
         m_ff[k]   <= m_in[k];
         s_ff[k]   <= s_w[k];
         neg_ff[k] <= neg_w[k];
      end

      assign rem_w[k+1] = rem_ff[k];
      assign acc_w[k+1] = acc_ff[k];
      assign m_w[k+1]   = m_ff[k];
      assign s_w[k+1]   = s_ff[k];
      assign neg_w[k+1] = neg_ff[k];
   end

   assign mag_out = m_w[NB];
   assign neg_out = neg_w[NB];

endmodule

// ===== test/triangle_face_normal_unit_tb.sv =====
// Self-checking testbench for the triangle face normal unit: directed table plus random triangles.
`timescale 1ns / 1ps
module triangle_face_normal_unit_tb;

   localparam int RANDOM_ITEMS = 1900;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic signed [tfn_pkg::COORD_BITS-1:0] CMIN =
      {1'b1, {(tfn_pkg::COORD_BITS-1){1'b0}}};
   localparam logic signed [tfn_pkg::COORD_BITS-1:0] CMAX =
      {1'b0, {(tfn_pkg::COORD_BITS-1){1'b1}}};
   localparam logic signed [tfn_pkg::OUT_BITS-1:0]   UNIT =
      tfn_pkg::OUT_BITS'(1) << tfn_pkg::NORMAL_FRAC_BITS;

   typedef logic signed [tfn_pkg::COORD_BITS-1:0] coord_type;
   typedef struct {
      coord_type v[9];
   } triangle_type;
   typedef struct {
      logic signed [tfn_pkg::OUT_BITS-1:0] nx, ny, nz;
      logic                                degen;
   } normal_type;
   typedef struct {
      triangle_type vtx;
      bit           typed;
      normal_type   want;
   } row_type;

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid, rsp_degenerate;
   coord_type req[9];
   logic signed [tfn_pkg::OUT_BITS-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;

   normal_type pending_normals[$];
   normal_type cur_want;
   bit         cur_typed;
   int         errors = 0;
   int         cycles = 0;

   triangle_face_normal_unit DUT (
      .clock, .reset, .start, .busy,
      .req_a_x(req[0]), .req_a_y(req[1]), .req_a_z(req[2]),
      .req_b_x(req[3]), .req_b_y(req[4]), .req_b_z(req[5]),
      .req_c_x(req[6]), .req_c_y(req[7]), .req_c_z(req[8]),
      .rsp_valid, .rsp_normal_x, .rsp_normal_y, .rsp_normal_z, .rsp_degenerate
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // exact magnitude search: largest m with m^2*|c|^2 <= 2^2F * c_i^2
   function automatic logic signed [tfn_pkg::OUT_BITS-1:0] unit_component(
         logic signed [63:0] c, logic [159:0] sum_sq);
      logic [159:0] mag, target, t;
      logic [15:0]  m;
      mag = 160'((c < 0) ? -c : c);
      target = (mag * mag) << (2 * tfn_pkg::NORMAL_FRAC_BITS);
      m = 0;
      for (int b = tfn_pkg::NORMAL_FRAC_BITS; b >= 0; b--) begin
         t = 160'(m | (16'd1 << b));
         if (t * t * sum_sq <= target) m = t[15:0];
      end
      return (c < 0) ? -$signed(m) : $signed(m);
   endfunction

   function automatic normal_type face_normal(triangle_type vtx);
      logic signed [63:0] p[9];
      logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
      logic [159:0] s, mx, my, mz;
      normal_type n;
      for (int i = 0; i < 9; i++) p[i] = 64'(vtx.v[i]);
      e1x = p[3] - p[0]; e1y = p[4] - p[1]; e1z = p[5] - p[2];
      e2x = p[6] - p[0]; e2y = p[7] - p[1]; e2z = p[8] - p[2];
      cx = e1y * e2z - e1z * e2y;
      cy = e1z * e2x - e1x * e2z;
      cz = e1x * e2y - e1y * e2x;
      mx = 160'((cx < 0) ? -cx : cx);
      my = 160'((cy < 0) ? -cy : cy);
      mz = 160'((cz < 0) ? -cz : cz);
      s = mx * mx + my * my + mz * mz;
      if (s == 0) begin
         n = '{0, 0, 0, 1'b1};
      end else begin
         n.nx = unit_component(cx, s);
         n.ny = unit_component(cy, s);
         n.nz = unit_component(cz, s);
         n.degen = 0;
      end
      return n;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
      errors++;
   endtask

   function automatic coord_type pick_extreme();
      case ($urandom_range(4))
         0: return CMIN;
         1: return CMAX;
         2: return 0;
         3: return 1;
         default: return -1;
      endcase
   endfunction

   function automatic triangle_type random_triangle();
      triangle_type t;
      int kind, k;
      coord_type d[3];
      kind = $urandom_range(9);
      for (int i = 0; i < 9; i++) t.v[i] = coord_type'($urandom);
      if (kind >= 4 && kind <= 6) begin
         // small triangle near a random anchor
         for (int i = 3; i < 9; i++)
            t.v[i] = coord_type'(t.v[i % 3] + $signed($urandom_range(510)) - 255);
      end else if (kind == 7) begin
         // collinear: C = A + k*(B - A)
         k = $signed($urandom_range(6)) - 3;
         for (int i = 0; i < 3; i++) begin
            d[i] = coord_type'($signed($urandom_range(200)) - 100);
            t.v[3 + i] = t.v[i] + d[i];
            t.v[6 + i] = coord_type'(t.v[i] + k * d[i]);
         end
      end else if (kind == 8) begin
         // shared coordinates along one axis
         k = $urandom_range(2);
         t.v[3 + k] = t.v[k];
         t.v[6 + k] = t.v[k];
      end else if (kind == 9) begin
         for (int i = 0; i < 9; i++) t.v[i] = pick_extreme();
      end
      return t;
   endfunction

   // one transaction: fields and start change at the falling edge
   task automatic send(triangle_type vtx, bit typed, normal_type want);
      @(negedge clock);
      for (int i = 0; i < 9; i++) req[i] = vtx.v[i];
      cur_typed = typed;
      cur_want  = want;
      start = 1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycle();
      @(negedge clock);
      start = 0;
   endtask

   task automatic drain();
      while (pending_normals.size() != 0) idle_cycle();
   endtask

   always @(posedge clock) begin
      normal_type w, got;
      cycles <= cycles + 1;
      if (!reset && start && !busy)
         pending_normals.insert(pending_normals.size(),
                                cur_typed ? cur_want : face_normal('{v: req}));
      if (!reset && rsp_valid) begin
         got = '{rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate};
         if (pending_normals.size() == 0) begin
            $display("UNEXPECTED result at cycle %0d", cycles);
            errors++;
         end else begin
            w = pending_normals.pop_front();
            if (got.nx !== w.nx) report_mismatch("normal_x", got.nx, w.nx);
            if (got.ny !== w.ny) report_mismatch("normal_y", got.ny, w.ny);
            if (got.nz !== w.nz) report_mismatch("normal_z", got.nz, w.nz);
            if (got.degen !== w.degen) report_mismatch("degenerate", got.degen, w.degen);
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("triangle_face_normal_unit_tb failed");
         $finish;
      end
   end

   row_type directed[] = '{
      '{'{'{0, 0, 0, 0, 0, 0, 0, 0, 0}}, 1, '{0, 0, 0, 1'b1}},
      '{'{'{0, 0, 0, 1, 0, 0, 0, 1, 0}}, 1, '{0, 0, UNIT, 1'b0}},
      '{'{'{0, 0, 0, 0, 1, 0, 1, 0, 0}}, 1, '{0, 0, -UNIT, 1'b0}},
      '{'{'{0, 0, 0, 0, 1, 0, 0, 0, 1}}, 1, '{UNIT, 0, 0, 1'b0}},
      '{'{'{0, 0, 0, 0, 0, 1, 1, 0, 0}}, 1, '{0, UNIT, 0, 1'b0}},
      '{'{'{5, 5, 5, 6, 6, 6, 9, 9, 9}}, 1, '{0, 0, 0, 1'b1}},
      '{'{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}}, 1, '{0, 0, 0, 1'b1}},
      '{'{'{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN}}, 0, '{0, 0, 0, 0}},
      '{'{'{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX}}, 0, '{0, 0, 0, 0}},
      '{'{'{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX}}, 0, '{0, 0, 0, 0}},
      '{'{'{CMAX, CMIN, 0, CMIN, CMAX, CMIN, 0, CMAX, CMIN}}, 0, '{0, 0, 0, 0}},
      '{'{'{0, 0, 0, 1, 1, 0, 1, 0, 1}}, 0, '{0, 0, 0, 0}},
      '{'{'{-1, -1, -1, 3, 7, -2, 1, -5, 4}}, 0, '{0, 0, 0, 0}},
      '{'{'{0, 0, 0, CMAX, 0, 0, 0, 1, 0}}, 0, '{0, 0, 0, 0}},
      '{'{'{0, 0, 0, 1, 2, 3, 2, 4, 6}}, 1, '{0, 0, 0, 1'b1}}
   };

   initial begin
      normal_type none;
      int sender_idle;
      none = '{0, 0, 0, 0};
      for (int i = 0; i < 9; i++) req[i] = 0;
      cur_typed = 0;
      cur_want = none;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (directed[r]) send(directed[r].vtx, directed[r].typed, directed[r].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) drain();
         sender_idle = (n < RANDOM_ITEMS / 3) ? 13 : (n < 2 * RANDOM_ITEMS / 3) ? 54 : 0;
         while ($urandom_range(99) < sender_idle) idle_cycle();
         send(random_triangle(), 0, none);
      end
      drain();
      repeat (tfn_pkg::LATENCY + 5) @(posedge clock);
      if (errors == 0) begin
         $display("triangle_face_normal_unit_tb passed");
      end else begin
         $display("triangle_face_normal_unit_tb failed");
      end
      $finish;
   end
endmodule
